// ----- hdl/psdes_pkg.sv -----
// ----------------------------------------------------------------------------
// psdes_pkg
// Shared types and constants of the pseudo-DES keystream byte cipher: round
// keys, seed reset value, and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package psdes_pkg;

    localparam int unsigned NUM_ROUNDS = 4;
    localparam int unsigned RND_W      = 2;

    localparam logic [31:0] SEED_RESET = 32'h8098_967F;
    localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;

    typedef logic [RND_W-1:0] rnd_t;

    // XOR key applied to the right half at the start of a round
    function automatic logic [31:0] rk_xor(input rnd_t r);
        logic [31:0] k;
        unique case (r)
            2'd0:    k = 32'hbaa9_6887;
            2'd1:    k = 32'h1e17_d32c;
            2'd2:    k = 32'h03bc_dc3c;
            default: k = 32'h0f33_d1b2;
        endcase
        return k;
    endfunction

    // XOR key applied to the swapped sum at the end of a round
    function automatic logic [31:0] rk_out(input rnd_t r);
        logic [31:0] k;
        unique case (r)
            2'd0:    k = 32'h4b0f_3b58;
            2'd1:    k = 32'he874_f0c3;
            2'd2:    k = 32'h6955_c5a6;
            default: k = 32'h55a7_ca46;
        endcase
        return k;
    endfunction

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;   // take the input item
        logic prep;   // set up the round halves
        logic mul;    // form the round products
        logic add;    // finish the round
        logic fin;    // store the keystream word, step the counter
        logic emit;   // write the result item
        rnd_t rnd;    // current round
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic need_word;  // the item on the input needs a fresh keystream word
        logic out_free;   // the output register can take a result this cycle
    } status_t;

endpackage

// ----- hdl/psdes_ctrl.sv -----
// ----------------------------------------------------------------------------
// psdes_ctrl
// Sequencer of the keystream cipher: takes one item at a time, steps the
// datapath through the four rounds when a new word is due, then writes the
// result item.
// ----------------------------------------------------------------------------
module psdes_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  psdes_pkg::status_t  sts,
    output psdes_pkg::cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0]      state_reg, state_next;
    psdes_pkg::rnd_t rnd_reg, rnd_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        cmd        = '0;
        cmd.rnd    = rnd_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.need_word ? ST_PREP : ST_EMIT;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                rnd_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add  = 1'b1;
                rnd_next = rnd_reg + 2'd1;
                if (rnd_reg == psdes_pkg::RND_W'(psdes_pkg::NUM_ROUNDS - 1))
                    state_next = ST_FIN;
                else
                    state_next = ST_MUL;
            end
            ST_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
        end
    end

endmodule

// ----- hdl/psdes_dpath.sv -----
// ----------------------------------------------------------------------------
// psdes_dpath
// Datapath of the keystream cipher: seed, counter and fixed words, the
// shared round unit (products in one cycle, sums in the next), the current
// keystream word and the output register.
// ----------------------------------------------------------------------------
module psdes_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data,
    input  logic [7:0]          data_byte,
    input  logic                buffer_start,
    input  logic                reseed,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [7:0]          out_byte,
    input  psdes_pkg::cmd_t     cmd,
    output psdes_pkg::status_t  sts
);

    logic [31:0] seed_reg;
    logic [31:0] counter_reg;
    logic [31:0] fixed_reg;
    logic [31:0] key_reg;
    logic [1:0]  phase_reg;
    logic [7:0]  data_reg;
    logic [31:0] left_reg;
    logic [31:0] right_reg;
    logic [31:0] lolo_reg;
    logic [31:0] hihi_reg;
    logic [31:0] lohi_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;

    logic [31:0] rnd_a;
    logic [31:0] rnd_b;
    logic [31:0] rnd_c;
    logic [31:0] rnd_right;
    logic [31:0] cnt_neg;
    logic [1:0]  ks_shift;
    logic [31:0] ks_word;

    // status for the controller
    assign sts.need_word = buffer_start | reseed | (phase_reg == 2'd0);
    assign sts.out_free  = ~out_valid_reg | out_ready;

    // round unit
    assign rnd_a     = right_reg ^ psdes_pkg::rk_xor(cmd.rnd);
    assign rnd_b     = lolo_reg + ~hihi_reg;
    assign rnd_c     = {rnd_b[15:0], rnd_b[31:16]};
    assign rnd_right = left_reg ^ ((rnd_c ^ psdes_pkg::rk_out(cmd.rnd)) + lohi_reg);

    assign cnt_neg   = 32'd0 - counter_reg;

    // keystream byte: the word shifted right by three less the phase
    assign ks_shift  = 2'd3 - phase_reg;
    assign ks_word   = key_reg >> ks_shift;

    // seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= psdes_pkg::SEED_RESET;
        else if (cfg_wr_en)
            seed_reg <= cfg_wr_data;
    end

    // counter, fixed word, keystream word and byte phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            fixed_reg   <= '0;
            key_reg     <= '0;
            phase_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (reseed)
                begin
                    counter_reg <= seed_reg;
                    fixed_reg   <= '0;
                end
                if (buffer_start | reseed)
                    phase_reg <= '0;
            end
            if (cmd.prep && ((counter_reg & psdes_pkg::SIGN_MASK) != '0))
            begin
                fixed_reg   <= cnt_neg;
                counter_reg <= 32'd1;
            end
            if (cmd.fin)
            begin
                key_reg     <= right_reg;
                counter_reg <= counter_reg + 32'd1;
            end
            if (cmd.emit)
                phase_reg <= phase_reg + 2'd1;
        end
    end

    // input byte, round halves and products
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            data_reg <= data_byte;
        if (cmd.prep)
        begin
            if ((counter_reg & psdes_pkg::SIGN_MASK) != '0)
            begin
                left_reg  <= cnt_neg;
                right_reg <= 32'd1;
            end
            else
            begin
                left_reg  <= fixed_reg;
                right_reg <= counter_reg;
            end
        end
        if (cmd.mul)
        begin
            lolo_reg <= 32'(rnd_a[15:0]  * rnd_a[15:0]);
            hihi_reg <= 32'(rnd_a[31:16] * rnd_a[31:16]);
            lohi_reg <= 32'(rnd_a[15:0]  * rnd_a[31:16]);
        end
        if (cmd.add)
        begin
            left_reg  <= right_reg;
            right_reg <= rnd_right;
        end
        if (cmd.emit)
            out_byte_reg <= data_reg ^ ks_word[7:0];
    end

    // output valid: set on a new result, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

endmodule

// ----- hdl/psdes_keystream_byte_cipher.sv -----
// ----------------------------------------------------------------------------
// psdes_keystream_byte_cipher
// Byte stream XOR cipher with a pseudo-DES hash keystream.
// ----------------------------------------------------------------------------
// One byte is taken at a time, and no new byte is taken until the last is
// emitted. A byte that uses the current keystream word goes from accept
// straight to emit, where it enters the output register. A byte that needs a
// fresh word (the first of a buffer, a reseed, or every fourth byte) goes
// through accept, set-up, the four rounds of the single shared round unit
// (products, then sums, each), store and emit. The output register lets a
// result wait while the next byte is accepted; a second result stalls in the
// emit step until the first is taken. The seed word (seed_reg) is to be
// written through cfg_wr_en / cfg_wr_data only while idle; the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
module psdes_keystream_byte_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        buffer_start,
    input  logic        reseed,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte
);

    psdes_pkg::cmd_t    cmd;
    psdes_pkg::status_t sts;

    // sequencer
    psdes_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    psdes_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .data_byte    (data_byte),
        .buffer_start (buffer_start),
        .reseed       (reseed),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
